FILE: sv/agss_pkg.sv
// Shared types and constants for the adaptive gain speed smoother.
package agss_pkg;

  // Field widths.
  localparam int DATA_W    = 16;
  localparam int GAIN_W    = 15;
  localparam int FRAC_BITS = 16;

  // Divider sizing follows from the sample, fraction and gain widths.
  localparam int DIVD_W = DATA_W + FRAC_BITS;
  localparam int ACC_W  = DIVD_W + 1;
  localparam int REM_W  = GAIN_W + 1;
  localparam int CNT_W  = $clog2(DIVD_W);

  // Configuration register indexes.
  localparam int            CFG_IDX_W     = 1;
  localparam [CFG_IDX_W-1:0] REG_MAX_GAIN  = 1'd0;
  localparam [CFG_IDX_W-1:0] REG_THRESHOLD = 1'd1;

  // Operation codes.
  localparam logic OP_INIT   = 1'b0;
  localparam logic OP_SAMPLE = 1'b1;

  // Reset and limit values.
  localparam [GAIN_W-1:0] MAX_GAIN_RST  = 15'd8;
  localparam [GAIN_W-1:0] THRESHOLD_RST = 15'd100;
  localparam [GAIN_W-1:0] MIN_DIVISOR   = 15'd2;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIFF,
    ST_DIV,
    ST_NEG,
    ST_ACC,
    ST_ADAPT,
    ST_DONE
  } state_t;

endpackage

FILE: sv/adaptive_gain_speed_smoother.sv
// A sample word runs through the difference, divide (32 restoring divider steps), sign,
// accumulate and adapt states; an init word goes from the difference step straight to done.
// The result waits in the done state only while the previous result has not yet been taken.
// The block takes no new word until the current one has been handed to the output register.
// Synchronous active-low reset: filtered value and fraction zero, divisor 2, previous
// difference zero, max_gain 8, threshold 100, no result pending.
module adaptive_gain_speed_smoother (
  input  logic                               clk,
  input  logic                               rst_n,
  // Input channel.
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic                               in_opcode,
  input  logic signed [agss_pkg::DATA_W-1:0] in_sample,
  // Result channel.
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic signed [agss_pkg::DATA_W-1:0] out_filtered,
  output logic        [agss_pkg::GAIN_W-1:0] out_divisor,
  // Configuration write channel.
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic     [agss_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic        [agss_pkg::GAIN_W-1:0] cfg_data
);

  localparam int DW = agss_pkg::DATA_W;
  localparam int GW = agss_pkg::GAIN_W;
  localparam int FB = agss_pkg::FRAC_BITS;
  localparam int VW = agss_pkg::DIVD_W;
  localparam int AW = agss_pkg::ACC_W;
  localparam int RW = agss_pkg::REM_W;
  localparam int CW = agss_pkg::CNT_W;

  // Sequencer and result handshake.
  agss_pkg::state_t state_r, state_nxt;
  logic             out_valid_r, out_valid_nxt;

  // Configuration registers.
  logic [GW-1:0] max_gain_r, max_gain_nxt;
  logic [GW-1:0] threshold_r, threshold_nxt;

  // Filter state.
  logic [DW-1:0] filt_r, filt_nxt;
  logic [FB-1:0] frac_r, frac_nxt;
  logic [GW-1:0] divisor_r, divisor_nxt;
  logic [DW-1:0] prev_diff_r, prev_diff_nxt;

  // Per-word working registers.
  logic          opcode_r, opcode_nxt;
  logic [DW-1:0] sample_r, sample_nxt;
  logic [DW-1:0] diff_r, diff_nxt;
  logic [VW-1:0] dq_r, dq_nxt;
  logic [RW-1:0] rem_r, rem_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;

  // Result register.
  logic [DW-1:0] res_filt_r, res_filt_nxt;
  logic [GW-1:0] res_div_r, res_div_nxt;

  // Combinational helpers.
  logic          in_acc;
  logic          out_free;
  logic [GW-1:0] gain_cap;
  logic [DW-1:0] diff_calc;
  logic [DW-1:0] diff_mag;
  logic [DW-1:0] resid;
  logic [RW-1:0] rem_shift;
  logic [RW:0]   trial;
  logic [AW-1:0] acc;
  logic          reach;
  logic          opposed;
  logic          halve;
  logic [GW-1:0] half_div;
  logic [GW:0]   dbl_div;

  assign in_ready     = (state_r == agss_pkg::ST_IDLE);
  assign cfg_ready    = 1'b1;
  assign out_valid    = out_valid_r;
  assign out_filtered = res_filt_r;
  assign out_divisor  = res_div_r;

  assign in_acc   = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;

  // A max_gain below two behaves as two.
  assign gain_cap = (max_gain_r < agss_pkg::MIN_DIVISOR) ? agss_pkg::MIN_DIVISOR : max_gain_r;

  // Difference and its magnitude; the most negative value maps onto its own bit pattern,
  // which read unsigned is the correct magnitude.
  assign diff_calc = sample_r - filt_r;
  assign diff_mag  = diff_r[DW-1] ? (~diff_r + 1'b1) : diff_r;

  // One restoring division step: shift in the next dividend bit and trial subtract.
  assign rem_shift = {rem_r[RW-2:0], dq_r[VW-1]};
  assign trial     = {1'b0, rem_shift} - {2'b00, divisor_r};

  // Signed quotient plus the zero-extended carried fraction.
  assign acc = {dq_r[VW-1], dq_r} + {{(AW-FB){1'b0}}, frac_r};

  // Adaptation decision.
  assign resid    = sample_r - filt_r;
  assign reach    = (diff_mag >= {{(DW-GW){1'b0}}, threshold_r});
  assign opposed  = (resid[DW-1] && !prev_diff_r[DW-1] && (prev_diff_r != '0)) ||
                    (!resid[DW-1] && (resid != '0) && prev_diff_r[DW-1]);
  assign halve    = reach && !opposed;
  assign half_div = divisor_r >> 1;
  assign dbl_div  = {divisor_r, 1'b0};

  // Sequencer, datapath and configuration next-state logic.
  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    max_gain_nxt  = max_gain_r;
    threshold_nxt = threshold_r;
    filt_nxt      = filt_r;
    frac_nxt      = frac_r;
    divisor_nxt   = divisor_r;
    prev_diff_nxt = prev_diff_r;
    opcode_nxt    = opcode_r;
    sample_nxt    = sample_r;
    diff_nxt      = diff_r;
    dq_nxt        = dq_r;
    rem_nxt       = rem_r;
    cnt_nxt       = cnt_r;
    res_filt_nxt  = res_filt_r;
    res_div_nxt   = res_div_r;

    // The pending result leaves when the consumer takes it.
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    // Configuration writes.
    if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        agss_pkg::REG_MAX_GAIN:  max_gain_nxt  = cfg_data;
        agss_pkg::REG_THRESHOLD: threshold_nxt = cfg_data;
        default: ;
      endcase
    end

    unique case (state_r)
      agss_pkg::ST_IDLE: begin
        if (in_acc) begin
          opcode_nxt = in_opcode;
          sample_nxt = in_sample;
          state_nxt  = agss_pkg::ST_DIFF;
        end
      end

      // Init clears the filter and sets the divisor to the capped gain; a sample loads the divider.
      agss_pkg::ST_DIFF: begin
        if (opcode_r == agss_pkg::OP_INIT) begin
          filt_nxt    = '0;
          frac_nxt    = '0;
          divisor_nxt = gain_cap;
          state_nxt   = agss_pkg::ST_DONE;
        end else begin
          diff_nxt  = diff_calc;
          dq_nxt    = {(diff_calc[DW-1] ? (~diff_calc + 1'b1) : diff_calc), {FB{1'b0}}};
          rem_nxt   = '0;
          cnt_nxt   = CW'(VW - 1);
          state_nxt = agss_pkg::ST_DIV;
        end
      end

      // One quotient bit per cycle.
      agss_pkg::ST_DIV: begin
        if (!trial[RW]) begin
          rem_nxt = trial[RW-1:0];
        end else begin
          rem_nxt = rem_shift;
        end
        dq_nxt = {dq_r[VW-2:0], !trial[RW]};
        if (cnt_r == '0) begin
          state_nxt = agss_pkg::ST_NEG;
        end else begin
          cnt_nxt = cnt_r - 1'b1;
        end
      end

      // Truncation toward zero: negate the magnitude quotient for a negative difference.
      agss_pkg::ST_NEG: begin
        if (diff_r[DW-1]) begin
          dq_nxt = ~dq_r + 1'b1;
        end
        state_nxt = agss_pkg::ST_ACC;
      end

      // Keep the low bits as the new fraction and add the integer part to the output.
      agss_pkg::ST_ACC: begin
        frac_nxt  = acc[FB-1:0];
        filt_nxt  = filt_r + acc[FB+DW-1:FB];
        state_nxt = agss_pkg::ST_ADAPT;
      end

      // Halve towards a floor of two, or double up to the cap.
      agss_pkg::ST_ADAPT: begin
        if (halve) begin
          divisor_nxt = (half_div < agss_pkg::MIN_DIVISOR) ? agss_pkg::MIN_DIVISOR : half_div;
        end else begin
          divisor_nxt = (dbl_div > {1'b0, gain_cap}) ? gain_cap : dbl_div[GW-1:0];
        end
        prev_diff_nxt = diff_r;
        state_nxt     = agss_pkg::ST_DONE;
      end

      // Hand the word to the result register once it is free.
      agss_pkg::ST_DONE: begin
        if (out_free) begin
          res_filt_nxt  = filt_r;
          res_div_nxt   = divisor_r;
          out_valid_nxt = 1'b1;
          state_nxt     = agss_pkg::ST_IDLE;
        end
      end

      default: state_nxt = agss_pkg::ST_IDLE;
    endcase
  end

  // Control, configuration and filter state, set to their reset values by reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= agss_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
      max_gain_r  <= agss_pkg::MAX_GAIN_RST;
      threshold_r <= agss_pkg::THRESHOLD_RST;
      filt_r      <= '0;
      frac_r      <= '0;
      divisor_r   <= agss_pkg::MIN_DIVISOR;
      prev_diff_r <= '0;
      cnt_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      max_gain_r  <= max_gain_nxt;
      threshold_r <= threshold_nxt;
      filt_r      <= filt_nxt;
      frac_r      <= frac_nxt;
      divisor_r   <= divisor_nxt;
      prev_diff_r <= prev_diff_nxt;
      cnt_r       <= cnt_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    opcode_r   <= opcode_nxt;
    sample_r   <= sample_nxt;
    diff_r     <= diff_nxt;
    dq_r       <= dq_nxt;
    rem_r      <= rem_nxt;
    res_filt_r <= res_filt_nxt;
    res_div_r  <= res_div_nxt;
  end

  // The divisor never falls below its floor, so the divider never sees zero.
  a_div_floor: assert property (@(posedge clk) disable iff (!rst_n)
    divisor_r >= agss_pkg::MIN_DIVISOR)
    else $error("divisor below floor");

  // The partial remainder stays below the divisor throughout the division.
  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == agss_pkg::ST_DIV) |-> (rem_r < {1'b0, divisor_r}))
    else $error("remainder not below divisor");

  // An accepted word always enters the difference step next.
  a_accept_seq: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> (state_r == agss_pkg::ST_DIFF))
    else $error("accepted word not sequenced");

  // The last division step is followed by the sign correction.
  a_div_end: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == agss_pkg::ST_DIV && cnt_r == '0) |=> (state_r == agss_pkg::ST_NEG))
    else $error("division did not finish");

  // Leaving the done state always presents a result.
  a_done_out: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == agss_pkg::ST_DONE && out_free) |=> (out_valid_r && in_ready))
    else $error("result not presented");

endmodule

FILE: sim/smoother_prediction_check.sv
// Checker for the speed smoother: watches all channels, predicts each result and compares.
`timescale 1ns / 1ps

module smoother_prediction_check
  import agss_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  input  logic                     in_ready,
  input  logic                     in_opcode,
  input  logic signed [DATA_W-1:0] in_sample,
  input  logic                     out_valid,
  input  logic                     out_ready,
  input  logic signed [DATA_W-1:0] out_filtered,
  input  logic        [GAIN_W-1:0] out_divisor,
  input  logic                     cfg_valid,
  input  logic                     cfg_ready,
  input  logic     [CFG_IDX_W-1:0] cfg_index,
  input  logic        [GAIN_W-1:0] cfg_data,
  output int                       mismatches,
  output int                       pending
);

  typedef struct packed {
    logic signed [DATA_W-1:0] filtered;
    logic        [GAIN_W-1:0] divisor;
  } smooth_result_t;

  // Our own copy of the filter state and its registers.
  logic signed [DATA_W-1:0] filt_m;
  logic        [DATA_W-1:0] frac_m;
  logic        [GAIN_W-1:0] divisor_m;
  logic signed [DATA_W-1:0] prev_diff_m;
  logic        [GAIN_W-1:0] gain_max_m;
  logic        [GAIN_W-1:0] thresh_m;

  smooth_result_t predicted_results[$];

  initial begin
    mismatches = 0;
    pending    = 0;
  end

  // Works out the result of one word and moves the filter state on.
  function automatic smooth_result_t smooth_step(logic op, logic signed [DATA_W-1:0] smp);
    logic signed [DATA_W-1:0] diff;
    logic signed [DATA_W-1:0] resid;
    longint                   acc;
    int                       cap;
    int                       next_div;
    int                       thr;
    bit                       fast;
    smooth_result_t           res;
    cap = (gain_max_m < MIN_DIVISOR) ? int'(MIN_DIVISOR) : int'(gain_max_m);
    if (op == OP_INIT) begin
      divisor_m = cap[GAIN_W-1:0];
      frac_m    = '0;
      filt_m    = '0;
    end else begin
      diff = smp - filt_m;
      // Signed division truncating toward zero, then the carried fraction on top.
      acc = (longint'(diff) * (longint'(1) << FRAC_BITS)) / longint'(divisor_m);
      acc = acc + longint'(frac_m);
      frac_m = acc[FRAC_BITS-1:0];
      // The integer part is the floor of the sum, so the bits above the fraction.
      filt_m = filt_m + acc[FRAC_BITS +: DATA_W];
      // Halve only on a large step whose residual does not oppose the last step.
      thr  = int'(thresh_m);
      fast = 1'b0;
      if (int'(diff) >= thr || int'(diff) <= -thr) begin
        resid = smp - filt_m;
        fast  = !((resid < 0 && prev_diff_m > 0) || (resid > 0 && prev_diff_m < 0));
      end
      if (fast) begin
        next_div = int'(divisor_m) / 2;
        if (next_div <= 1) next_div = int'(MIN_DIVISOR);
      end else begin
        next_div = int'(divisor_m) * 2;
        if (next_div > cap) next_div = cap;
      end
      divisor_m   = next_div[GAIN_W-1:0];
      prev_diff_m = diff;
    end
    res.filtered = filt_m;
    res.divisor  = divisor_m;
    return res;
  endfunction

  // Prints one line per mismatch and counts it.
  task automatic report_mismatch(string what, int got, int want);
    $display("ERROR at %0t ns: %s is %0d, predicted %0d", $time, what, got, want);
    mismatches = mismatches + 1;
  endtask

  // Predict on each accepted input word, compare each accepted result word.
  always @(posedge clk) begin
    smooth_result_t want;
    if (!rst_n) begin
      filt_m      = '0;
      frac_m      = '0;
      divisor_m   = MIN_DIVISOR;
      prev_diff_m = '0;
      gain_max_m  = MAX_GAIN_RST;
      thresh_m    = THRESHOLD_RST;
      predicted_results.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_MAX_GAIN)
          gain_max_m = cfg_data;
        else if (cfg_index == REG_THRESHOLD)
          thresh_m = cfg_data;
      end
      if (in_valid && in_ready)
        predicted_results.push_back(smooth_step(in_opcode, in_sample));
      if (out_valid && out_ready) begin
        if (predicted_results.size() == 0) begin
          report_mismatch("unexpected result word, filtered", int'(out_filtered), 0);
        end else begin
          want = predicted_results.pop_front();
          if (out_filtered !== want.filtered)
            report_mismatch("filtered", int'(out_filtered), int'(want.filtered));
          if (out_divisor !== want.divisor)
            report_mismatch("divisor", int'(out_divisor), int'(want.divisor));
        end
      end
    end
    pending <= predicted_results.size();
  end

endmodule

FILE: sim/adaptive_gain_speed_smoother_test.sv
// Testbench top for the speed smoother: clock, reset, stimulus, idling and the verdict.
`timescale 1ns / 1ps

module adaptive_gain_speed_smoother_test;
  import agss_pkg::*;

  logic                     clk;
  logic                     rst_n;
  logic                     in_valid;
  logic                     in_ready;
  logic                     in_opcode;
  logic signed [DATA_W-1:0] in_sample;
  logic                     out_valid;
  logic                     out_ready;
  logic signed [DATA_W-1:0] out_filtered;
  logic        [GAIN_W-1:0] out_divisor;
  logic                     cfg_valid;
  logic                     cfg_ready;
  logic     [CFG_IDX_W-1:0] cfg_index;
  logic        [GAIN_W-1:0] cfg_data;

  int mismatches;
  int pending;

  // Shared between the sender and the receiver.
  bit no_idle;
  bit hold_off_request;

  adaptive_gain_speed_smoother uut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_opcode    (in_opcode),
    .in_sample    (in_sample),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_filtered (out_filtered),
    .out_divisor  (out_divisor),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  smoother_prediction_check u_check (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_opcode    (in_opcode),
    .in_sample    (in_sample),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_filtered (out_filtered),
    .out_divisor  (out_divisor),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .mismatches   (mismatches),
    .pending      (pending)
  );

  // 100 MHz clock.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard limit on the run, several times the slowest correct run.
  initial begin
    #5_000_000;
    $display("Mismatches found");
    $finish;
  end

  // Receiver: random stalls, none while no_idle is set, and one long hold-off.
  initial begin
    int stall_left;
    bit hold_done;
    stall_left = 0;
    hold_done  = 1'b0;
    out_ready  = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off_request && !hold_done) begin
        stall_left = 400;
        hold_done  = 1'b1;
      end
      if (stall_left > 0) begin
        stall_left = stall_left - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= no_idle || ($urandom_range(99) >= 15);
      end
    end
  end

  // Offers one input word, sometimes after a random gap, and waits for it to be taken.
  task automatic offer_word(input logic op, input int smp);
    @(negedge clk);
    if (!no_idle && $urandom_range(99) < 15) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 45)) @(negedge clk);
    end
    in_valid  <= 1'b1;
    in_opcode <= op;
    in_sample <= smp[DATA_W-1:0];
    do @(posedge clk); while (!in_ready);
  endtask

  // Stops offering and waits until every predicted result has come back.
  task automatic wait_until_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (40) @(negedge clk);
  endtask

  // Writes one configuration register.
  task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input int value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value[GAIN_W-1:0];
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic int pick_max_gain();
    case ($urandom_range(6))
      0:       return 0;
      1:       return 1;
      2:       return 2;
      3:       return 16384;
      4:       return 32767;
      5:       return $urandom_range(2, 64);
      default: return $urandom_range(2, 16384);
    endcase
  endfunction

  function automatic int pick_threshold();
    case ($urandom_range(5))
      0:       return 0;
      1:       return 1;
      2:       return 32767;
      3:       return $urandom_range(0, 500);
      default: return $urandom_range(0, 32767);
    endcase
  endfunction

  // Stimulus and verdict.
  initial begin
    int level;
    int roll;
    no_idle          = 1'b0;
    hold_off_request = 1'b0;
    in_valid         = 1'b0;
    in_opcode        = OP_INIT;
    in_sample        = '0;
    cfg_valid        = 1'b0;
    cfg_index        = REG_MAX_GAIN;
    cfg_data         = '0;
    rst_n            = 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed: samples straight from reset, init, then the sample extremes.
    offer_word(OP_SAMPLE, 1000);
    offer_word(OP_SAMPLE, 1000);
    offer_word(OP_INIT, 32767);
    offer_word(OP_SAMPLE, 32767);
    offer_word(OP_SAMPLE, -32768);
    offer_word(OP_SAMPLE, 0);
    offer_word(OP_SAMPLE, -1);
    offer_word(OP_SAMPLE, 1);
    offer_word(OP_SAMPLE, -300);
    wait_until_idle();

    // Maximum gain below two and a zero threshold.
    write_register(REG_MAX_GAIN, 1);
    write_register(REG_THRESHOLD, 0);
    offer_word(OP_INIT, 0);
    offer_word(OP_SAMPLE, 200);
    offer_word(OP_SAMPLE, -200);
    offer_word(OP_SAMPLE, 5);
    wait_until_idle();
    write_register(REG_MAX_GAIN, 0);
    offer_word(OP_INIT, -1);
    offer_word(OP_SAMPLE, 7);
    wait_until_idle();

    // Largest gain and threshold: only a difference of magnitude 32767 or the most negative one reaches it.
    write_register(REG_MAX_GAIN, 32767);
    write_register(REG_THRESHOLD, 32767);
    offer_word(OP_INIT, 0);
    offer_word(OP_SAMPLE, -32768);
    offer_word(OP_SAMPLE, 32767);
    offer_word(OP_SAMPLE, 16384);
    offer_word(OP_SAMPLE, -16384);
    wait_until_idle();
    write_register(REG_MAX_GAIN, 16384);
    write_register(REG_THRESHOLD, 1);
    offer_word(OP_INIT, 0);
    offer_word(OP_SAMPLE, 100);
    offer_word(OP_SAMPLE, 0);

    // Random phases: mostly a wandering speed with steps, some noise and inits.
    level = 0;
    for (int phase = 0; phase < 9; phase++) begin
      wait_until_idle();
      write_register(REG_MAX_GAIN, pick_max_gain());
      write_register(REG_THRESHOLD, pick_threshold());
      no_idle = (phase == 2);
      offer_word(OP_INIT, $urandom);
      for (int k = 0; k < 104; k++) begin
        if (phase == 5 && k == 20) hold_off_request = 1'b1;
        roll = $urandom_range(99);
        if (roll < 4) begin
          offer_word(OP_INIT, $urandom);
        end else if (roll < 60) begin
          level = level + $urandom_range(0, 64) - 32;
          offer_word(OP_SAMPLE, level);
        end else if (roll < 75) begin
          level = $urandom_range(0, 65535) - 32768;
          offer_word(OP_SAMPLE, level);
        end else begin
          offer_word(OP_SAMPLE, $urandom);
        end
      end
    end
    no_idle = 1'b0;
    wait_until_idle();

    if (mismatches == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule

FILE: files.f
sv/agss_pkg.sv
sv/adaptive_gain_speed_smoother.sv
sim/smoother_prediction_check.sv
sim/adaptive_gain_speed_smoother_test.sv
